>>> rtl/core/fsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_pkg: shared types and constants of the fraction sum reducer
// Character codes, parser phase, controller states and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fsr_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam int unsigned DEC_BASE = 10;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_NUM  = 2'd1,
        PH_DEN  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        MS_P1 = 2'd0,   // |acc num| * term den
        MS_P2 = 2'd1,   // acc den * term num
        MS_ND = 2'd2    // acc den * term den
    } t_mul_slot;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_MUL1     = 10'b00_0000_0010,
        S_MUL2     = 10'b00_0000_0100,
        S_MUL3     = 10'b00_0000_1000,
        S_ACCUM    = 10'b00_0001_0000,
        S_GCD_LOAD = 10'b00_0010_0000,
        S_GCD      = 10'b00_0100_0000,
        S_DIV_N    = 10'b00_1000_0000,
        S_DIV_D    = 10'b01_0000_0000,
        S_OUT      = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic      accept;
        logic      mul_en;
        t_mul_slot mul_slot;
        logic      accum;
        logic      gcd_load;
        logic      gcd_step;
        logic      div_start;
        logic      div_den;
        logic      div_step;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic go_finish;    // accepted word closes a term
        logic in_last;      // accepted word carries the end mark
        logic last;         // term being finished was closed by the end mark
        logic skip_reduce;  // sum is zero or overflowed: no reduction
        logic gcd_done;
        logic div_done;
    } t_status;

endpackage

>>> rtl/core/fraction_sum_reducer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_sum_reducer_top: text-fed rational sum with GCD reduction
// Adds a sum of signed fractions given one ASCII character per word and
// emits the reduced numerator and denominator after the end mark.
// ----------------------------------------------------------------------------
// Feed the expression one character per input word, e.g. "-1/2+1/3", and
// raise i_end_of_expr on its last character. Digits, '+', '-' and '/' are
// parsed; every other character is dropped. A digit, slash or dropped
// character without the end mark is taken with no stall. A sign that
// closes a term steps through MUL1, MUL2, MUL3 and ACCUM: the single shared
// multiplier forms the three cross products and ACCUM folds them into the
// running fraction. The end mark adds the open term, then reduces: a binary
// GCD loop followed by two restoring divisions, one quotient bit per cycle.
// A zero or overflowed sum skips the reduction. The result sits in an
// output register, so the next expression can stream in while it waits;
// the input stalls while a term is closed or a sum reduced, and also once
// the next end mark has been taken and its result is ready while that
// register is still full.
// Zero is given as 0/1, and o_overflow is set with 0/1 when the sum leaves
// the accumulator or the reduced result does not fit 32 signed / 31 unsigned
// bits.
// ----------------------------------------------------------------------------
module fraction_sum_reducer_top
    import fsr_pkg::*;
#(
    parameter int ACC_WIDTH     = 48,
    parameter int OPERAND_WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // character input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_end_of_expr,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_sum_numerator,
    output logic [30:0]        o_sum_denominator,
    output logic               o_overflow
);

    t_cmd    cmd;
    t_status status;

    // sequencer: handshakes and step order
    fsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // parser, accumulator, reduction and result register
    fsr_dpath #(
        .ACC_WIDTH     (ACC_WIDTH),
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_char_code       (i_char_code),
        .i_end_of_expr     (i_end_of_expr),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_sum_numerator   (o_sum_numerator),
        .o_sum_denominator (o_sum_denominator),
        .o_overflow        (o_overflow)
    );

endmodule

>>> rtl/core/fsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_ctrl: sequencer of the fraction sum reducer
// One-hot state machine that steps the datapath through parse, term
// accumulation, GCD reduction and result hand-off.
// ----------------------------------------------------------------------------
module fsr_ctrl
    import fsr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    // output register can take a word when empty or being drained now
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.go_finish) begin
                        n_state = S_MUL1;
                    end else if (i_status.in_last) begin
                        n_state = S_GCD_LOAD;
                    end
                end
            end
            S_MUL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_slot = MS_P1;
                n_state        = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_slot = MS_P2;
                n_state        = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_slot = MS_ND;
                n_state        = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_status.last ? S_GCD_LOAD : S_IDLE;
            end
            S_GCD_LOAD: begin
                o_cmd.gcd_load = 1'b1;
                n_state        = i_status.skip_reduce ? S_OUT : S_GCD;
            end
            S_GCD: begin
                if (i_status.gcd_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV_N;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV_N: begin
                if (i_status.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_den   = 1'b1;
                    n_state         = S_DIV_D;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DIV_D: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/core/fsr_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_dpath: datapath of the fraction sum reducer
// Character parser, sign-magnitude accumulator with one shared multiplier,
// binary GCD unit, restoring divider and the result register.
// ----------------------------------------------------------------------------
module fsr_dpath
    import fsr_pkg::*;
#(
    parameter int ACC_WIDTH     = 48,
    parameter int OPERAND_WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_char_code,
    input  logic               i_end_of_expr,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic signed [31:0] o_sum_numerator,
    output logic [30:0]        o_sum_denominator,
    output logic               o_overflow
);

    localparam int W  = ACC_WIDTH - 1;           // magnitude width
    localparam int PW = W + OPERAND_WIDTH;       // full product width
    localparam int GW = OPERAND_WIDTH + 4;       // operand growth width
    localparam int CW = $clog2(W + 1);

    function automatic logic [OPERAND_WIDTH-1:0] grow(
        input logic [OPERAND_WIDTH-1:0] v,
        input logic [3:0]               d
    );
        logic [GW-1:0] r;
        r = GW'(v) * GW'(DEC_BASE) + GW'(d);
        grow = (|r[GW-1:OPERAND_WIDTH]) ? '1 : r[OPERAND_WIDTH-1:0];
    endfunction

    // parser and accumulator state
    t_phase                   r_phase;
    logic                     r_term_neg;
    logic [OPERAND_WIDTH-1:0] r_term_num;
    logic [OPERAND_WIDTH-1:0] r_term_den;
    logic                     r_pend_sign;
    logic                     r_pend_neg;
    logic                     r_last;
    logic                     r_acc_neg;
    logic [W-1:0]             r_acc_mag;
    logic [W-1:0]             r_acc_den;
    logic                     r_acc_ovf;

    // products
    logic [W-1:0]             r_p1;
    logic [W-1:0]             r_p2;
    logic [W-1:0]             r_nd;
    logic                     r_mul_ovf;

    // GCD and divider
    logic [W-1:0]             r_ga;
    logic [W-1:0]             r_gb;
    logic [CW-1:0]            r_gk;
    logic [W-1:0]             r_dv_rem;
    logic [W-1:0]             r_dv_quo;
    logic [W-1:0]             r_dv_div;
    logic [CW-1:0]            r_dv_cnt;
    logic [W-1:0]             r_qn;

    // result
    logic [31:0]              r_out_num;
    logic [30:0]              r_out_den;
    logic                     r_out_ovf;

    logic                     is_digit;
    logic                     is_slash;
    logic                     is_minus;
    logic                     is_sign;
    logic [7:0]               digit_full;
    logic                     term_open;
    logic [OPERAND_WIDTH-1:0] td_eff;
    logic [W-1:0]             mul_a;
    logic [OPERAND_WIDTH-1:0] mul_b;
    logic [PW-1:0]            prod;
    logic                     prod_big;
    logic [W:0]               fin_mag;
    logic                     fin_neg;
    logic                     fin_ovf;
    logic                     acc_zero;
    logic [W-1:0]             g_val;
    logic [W:0]               trial;
    logic [W:0]               trial_sub;
    logic                     trial_ge;
    logic [W-1:0]             lim_num;
    logic                     range_bad;
    logic [31:0]              qn_low;

    // ---- input decode ----
    assign digit_full = i_char_code - CH_ZERO;
    assign is_digit   = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign is_slash   = (i_char_code == CH_SLASH);
    assign is_minus   = (i_char_code == CH_MINUS);
    assign is_sign    = is_minus || (i_char_code == CH_PLUS);
    assign term_open  = (r_phase != PH_IDLE);

    // ---- shared multiplier ----
    assign td_eff   = (r_term_den == '0) ? OPERAND_WIDTH'(1) : r_term_den;
    assign mul_a    = (i_cmd.mul_slot == MS_P1) ? r_acc_mag : r_acc_den;
    assign mul_b    = (i_cmd.mul_slot == MS_P2) ? r_term_num : td_eff;
    assign prod     = PW'(mul_a) * PW'(mul_b);
    assign prod_big = |prod[PW-1:W];

    // ---- signed combine of the cross products ----
    always_comb begin
        if (r_acc_neg == r_term_neg) begin
            fin_mag = {1'b0, r_p1} + {1'b0, r_p2};
            fin_neg = r_acc_neg;
        end else if (r_p1 >= r_p2) begin
            fin_mag = {1'b0, r_p1 - r_p2};
            fin_neg = r_acc_neg;
        end else begin
            fin_mag = {1'b0, r_p2 - r_p1};
            fin_neg = r_term_neg;
        end
    end
    assign fin_ovf  = r_mul_ovf || fin_mag[W];
    assign acc_zero = (r_acc_mag == '0);

    // ---- GCD and divider helpers ----
    assign g_val     = r_ga << r_gk;
    assign trial     = {r_dv_rem, r_dv_quo[W-1]};
    assign trial_sub = trial - {1'b0, r_dv_div};
    assign trial_ge  = (trial >= {1'b0, r_dv_div});

    // ---- result range ----
    assign lim_num   = r_acc_neg ? W'(33'h0_8000_0000) : W'(32'h7FFF_FFFF);
    assign range_bad = (r_dv_quo > W'(32'h7FFF_FFFF)) || (r_qn > lim_num);
    assign qn_low    = r_qn[31:0];

    assign o_status.go_finish   = i_end_of_expr ? (is_digit || is_slash || term_open)
                                                : (is_sign && term_open);
    assign o_status.in_last     = i_end_of_expr;
    assign o_status.last        = r_last;
    assign o_status.skip_reduce = r_acc_ovf || acc_zero;
    assign o_status.gcd_done    = (r_ga == r_gb);
    assign o_status.div_done    = (r_dv_cnt == CW'(W));

    // ---- parser and accumulator ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_term_neg  <= 1'b0;
            r_term_num  <= '0;
            r_term_den  <= '0;
            r_pend_sign <= 1'b0;
            r_pend_neg  <= 1'b0;
            r_last      <= 1'b0;
            r_acc_neg   <= 1'b0;
            r_acc_mag   <= '0;
            r_acc_den   <= W'(1);
            r_acc_ovf   <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_last      <= i_end_of_expr;
                r_pend_sign <= is_sign;
                r_pend_neg  <= is_minus;
                if (is_digit) begin
                    if (r_phase == PH_DEN) begin
                        r_term_den <= grow(r_term_den, digit_full[3:0]);
                    end else begin
                        r_phase    <= PH_NUM;
                        r_term_num <= grow(r_term_num, digit_full[3:0]);
                    end
                end else if (is_slash) begin
                    r_phase <= PH_DEN;
                end else if (is_sign && !term_open) begin
                    r_term_neg <= is_minus;
                end
            end
            if (i_cmd.accum) begin
                if (!r_acc_ovf) begin
                    if (fin_ovf) begin
                        r_acc_ovf <= 1'b1;
                    end else begin
                        r_acc_mag <= fin_mag[W-1:0];
                        r_acc_neg <= fin_neg && (|fin_mag[W-1:0]);
                        r_acc_den <= r_nd;
                    end
                end
                // close the term, then apply the sign that closed it
                r_phase    <= PH_IDLE;
                r_term_num <= '0;
                r_term_den <= '0;
                r_term_neg <= r_pend_sign && r_pend_neg;
            end
            if (i_cmd.out_load) begin
                r_phase     <= PH_IDLE;
                r_term_neg  <= 1'b0;
                r_term_num  <= '0;
                r_term_den  <= '0;
                r_pend_sign <= 1'b0;
                r_pend_neg  <= 1'b0;
                r_last      <= 1'b0;
                r_acc_neg   <= 1'b0;
                r_acc_mag   <= '0;
                r_acc_den   <= W'(1);
                r_acc_ovf   <= 1'b0;
            end
        end
    end

    // ---- products, GCD, divider, result ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_slot)
                MS_P1: begin
                    r_p1      <= prod[W-1:0];
                    r_mul_ovf <= prod_big;
                end
                MS_P2: begin
                    r_p2      <= prod[W-1:0];
                    r_mul_ovf <= r_mul_ovf || prod_big;
                end
                MS_ND: begin
                    r_nd      <= prod[W-1:0];
                    r_mul_ovf <= r_mul_ovf || prod_big;
                end
                default: begin
                    r_mul_ovf <= 1'b1;
                end
            endcase
        end

        if (i_cmd.gcd_load) begin
            r_ga <= r_acc_mag;
            r_gb <= r_acc_den;
            r_gk <= '0;
        end else if (i_cmd.gcd_step) begin
            priority if (!r_ga[0] && !r_gb[0]) begin
                r_ga <= r_ga >> 1;
                r_gb <= r_gb >> 1;
                r_gk <= r_gk + CW'(1);
            end else if (!r_ga[0]) begin
                r_ga <= r_ga >> 1;
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga > r_gb) begin
                r_ga <= (r_ga - r_gb) >> 1;
            end else begin
                r_gb <= (r_gb - r_ga) >> 1;
            end
        end

        if (i_cmd.div_start) begin
            r_dv_rem <= '0;
            r_dv_cnt <= '0;
            if (i_cmd.div_den) begin
                r_qn     <= r_dv_quo;
                r_dv_quo <= r_acc_den;
            end else begin
                r_dv_quo <= r_acc_mag;
                r_dv_div <= g_val;
            end
        end else if (i_cmd.div_step) begin
            r_dv_rem <= trial_ge ? trial_sub[W-1:0] : trial[W-1:0];
            r_dv_quo <= {r_dv_quo[W-2:0], trial_ge};
            r_dv_cnt <= r_dv_cnt + CW'(1);
        end

        if (i_cmd.out_load) begin
            priority if (r_acc_ovf) begin
                r_out_num <= '0;
                r_out_den <= 31'd1;
                r_out_ovf <= 1'b1;
            end else if (acc_zero) begin
                r_out_num <= '0;
                r_out_den <= 31'd1;
                r_out_ovf <= 1'b0;
            end else if (range_bad) begin
                r_out_num <= '0;
                r_out_den <= 31'd1;
                r_out_ovf <= 1'b1;
            end else begin
                r_out_num <= r_acc_neg ? (32'd0 - qn_low) : qn_low;
                r_out_den <= r_dv_quo[30:0];
                r_out_ovf <= 1'b0;
            end
        end
    end

    assign o_sum_numerator   = $signed(r_out_num);
    assign o_sum_denominator = r_out_den;
    assign o_overflow        = r_out_ovf;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the fraction sum reducer
// Streams fraction-sum expressions one ASCII character per word and checks
// every reduced result against an in-bench model of the parser and the
// rational accumulator. A directed table comes first, then random
// expressions, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import fsr_pkg::*;

    localparam int ACC_W = 48;
    localparam int OPER_W = 8;
    localparam logic [63:0] ACC_MAX = (64'd1 << (ACC_W - 1)) - 64'd1;
    localparam int unsigned OPER_SAT = (1 << OPER_W) - 1;
    localparam int RANDOM_WORDS = 1090;    // words sent in the random part
    localparam int HOLD_AT = 30;           // result count at which the sink holds off
    localparam int LONG_HOLD = 400;        // length of that hold, in cycles
    localparam int DRAIN_CYCLES = 4 * ACC_W + 40;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               ovf;
    } t_frac;

    typedef struct {
        string text;
        bit    nul_end;    // append a NUL word that carries the end mark
        bit    typed;      // expected result given in the row
        t_frac want;
    } t_case;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_char_code = 8'h00;
    logic               i_end_of_expr = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_sum_numerator;
    logic [30:0]        o_sum_denominator;
    logic               o_overflow;

    // model state: running fraction and the term being parsed
    logic signed [ACC_W-1:0] sum_num;
    logic [ACC_W-1:0]        sum_den;
    bit                      sum_ovf;
    bit                      term_neg;
    logic [OPER_W-1:0]       term_num;
    logic [OPER_W-1:0]       term_den;
    t_phase                  phase;

    t_frac      pending[$];     // reduced sums still owed by the block
    t_case      cases[$];
    logic [7:0] expr_q[$];      // characters of the expression being sent
    t_frac      head;
    int         fails = 0;
    int         sent_words = 0;
    int         taken = 0;
    int         quiet = 0;
    bit         calm = 1'b0;    // no gaps on either side for this expression

    always #5 i_clk = ~i_clk;

    fraction_sum_reducer_top #(
        .ACC_WIDTH    (ACC_W),
        .OPERAND_WIDTH(OPER_W)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_char_code      (i_char_code),
        .i_end_of_expr    (i_end_of_expr),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_sum_numerator  (o_sum_numerator),
        .o_sum_denominator(o_sum_denominator),
        .o_overflow       (o_overflow)
    );

    // ------------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------------

    // Append one decimal digit, saturating at the operand width.
    function automatic logic [OPER_W-1:0] add_digit(logic [OPER_W-1:0] v, logic [7:0] d);
        int unsigned x;
        x = v * DEC_BASE + d;
        return (x > OPER_SAT) ? OPER_SAT[OPER_W-1:0] : x[OPER_W-1:0];
    endfunction

    // True when a*b stays inside the accumulator magnitude.
    function automatic bit product_fits(logic [63:0] a, logic [63:0] b);
        return (b == 64'd0) || (a <= ACC_MAX / b);
    endfunction

    task automatic clear_term();
        term_neg = 1'b0;
        term_num = '0;
        term_den = '0;
        phase = PH_IDLE;
    endtask

    task automatic clear_sum();
        sum_num = '0;
        sum_den = ACC_W'(1);
        sum_ovf = 1'b0;
        clear_term();
    endtask

    // Fold the open term into the running fraction by cross multiplication.
    task automatic close_term();
        logic [63:0] td, tn, am, p1, p2, nd, mag, sv;
        longint      s;
        bit          an, neg, ovf;
        if (phase == PH_IDLE)
            return;
        if (!sum_ovf) begin
            td = (term_den != 0) ? 64'(term_den) : 64'd1;
            tn = 64'(term_num);
            s = sum_num;
            an = (s < 0);
            am = an ? -s : s;
            ovf = !product_fits(am, td) || !product_fits(64'(sum_den), tn)
                  || !product_fits(64'(sum_den), td);
            p1 = am * td;
            p2 = 64'(sum_den) * tn;
            nd = 64'(sum_den) * td;
            if (an == term_neg) begin
                mag = p1 + p2;
                neg = an;
            end else if (p1 >= p2) begin
                mag = p1 - p2;
                neg = an;
            end else begin
                mag = p2 - p1;
                neg = term_neg;
            end
            if (mag > ACC_MAX)
                ovf = 1'b1;
            if (ovf) begin
                sum_ovf = 1'b1;
            end else begin
                sv = neg ? -mag : mag;
                sum_num = sv[ACC_W-1:0];
                sum_den = nd[ACC_W-1:0];
            end
        end
        clear_term();
    endtask

    // Reduce the running fraction by its GCD and fit it to the result fields.
    task automatic reduce_sum(output t_frac r);
        logic [63:0] nm, dn, a, b, t, sn;
        longint      s;
        bit          neg, ovf;
        s = sum_num;
        neg = (s < 0);
        nm = neg ? -s : s;
        dn = 64'(sum_den);
        ovf = sum_ovf;
        if (!ovf) begin
            if (nm == 0 || dn == 0) begin
                nm = 64'd0;
                dn = 64'd1;
                neg = 1'b0;
            end else begin
                a = nm;
                b = dn;
                while (b != 0) begin
                    t = a % b;
                    a = b;
                    b = t;
                end
                nm = nm / a;
                dn = dn / a;
            end
            if (dn > 64'h7FFF_FFFF || nm > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF))
                ovf = 1'b1;
        end
        if (ovf) begin
            r.num = '0;
            r.den = 31'd1;
            r.ovf = 1'b1;
        end else begin
            sn = neg ? -nm : nm;
            r.num = sn[31:0];
            r.den = dn[30:0];
            r.ovf = 1'b0;
        end
    endtask

    // Advance the model by one accepted word; got is set when a result is due.
    task automatic absorb_word(input logic [7:0] c, input bit last,
                               output bit got, output t_frac r);
        got = 1'b0;
        r.num = '0;
        r.den = 31'd1;
        r.ovf = 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (phase == PH_DEN) begin
                term_den = add_digit(term_den, c - CH_ZERO);
            end else begin
                phase = PH_NUM;
                term_num = add_digit(term_num, c - CH_ZERO);
            end
        end else if (c == CH_SLASH) begin
            phase = PH_DEN;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            close_term();
            term_neg = (c == CH_MINUS);
        end
        if (last) begin
            close_term();
            reduce_sum(r);
            clear_sum();
            got = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Append one character to the expression being built.
    task automatic put_char(input logic [7:0] c);
        expr_q.insert(expr_q.size(), c);
    endtask

    // Offer one word after a random gap and hold it until the block takes it.
    // Valid stays high across back-to-back words, so it is lowered only when
    // a gap is drawn.
    task automatic send_word(input logic [7:0] c, input bit last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_code <= c;
        i_end_of_expr <= last;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Send expr_q with the end mark on its last word and queue the result,
    // taken from the table row when one is typed in, else from the model.
    task automatic run_expr(input bit typed, input t_frac want);
        t_frac r;
        bit    got, last;
        int    i;
        for (i = 0; i < expr_q.size(); i++) begin
            last = (i == expr_q.size() - 1);
            send_word(expr_q[i], last);
            absorb_word(expr_q[i], last, got, r);
            sent_words++;
            if (got) begin
                if (typed)
                    pending.insert(pending.size(), want);
                else
                    pending.insert(pending.size(), r);
            end
        end
    endtask

    task automatic add_case(input string text, input bit nul_end, input bit typed,
                            input int num, input int den, input bit ovf);
        t_case c;
        c.text = text;
        c.nul_end = nul_end;
        c.typed = typed;
        c.want.num = num;
        c.want.den = 31'(den);
        c.want.ovf = ovf;
        cases.insert(cases.size(), c);
    endtask

    // Put a decimal number: mostly one or two digits, now and then a long
    // one that saturates, rarely none at all.
    task automatic put_number();
        int n;
        case ($urandom_range(0, 19))
            0:       n = 0;
            1, 2:    n = $urandom_range(3, 4);
            default: n = $urandom_range(1, 2);
        endcase
        repeat (n) put_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Build a random expression: mostly well-formed signed terms with random
    // digits, sprinkled with stray characters, doubled signs and missing
    // slashes; one in twenty is pure noise.
    task automatic build_expr();
        int terms, k;
        expr_q.delete();
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6)) put_char(8'($urandom_range(0, 255)));
            return;
        end
        terms = $urandom_range(1, 4);
        for (k = 0; k < terms; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: put_char(CH_PLUS);
                4, 5, 6:    put_char(CH_MINUS);
                7: begin
                    put_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    put_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                end
                8: begin
                    if (k != 0)
                        put_char(CH_MINUS);
                end
                default: ;  // no sign: digits run into the previous term
            endcase
            put_number();
            if ($urandom_range(0, 9) != 0) begin
                put_char(CH_SLASH);
                put_number();
            end
            if ($urandom_range(0, 14) == 0)
                put_char(8'($urandom_range(0, 255)));
        end
        if (expr_q.size() == 0)
            put_char(CH_PLUS);
    endtask

    // ------------------------------------------------------------------------
    // Result sink: draw a stall per result; once, hold off long enough that
    // the output register stays full and the next end mark backs up the input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int n;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (taken == HOLD_AT)
                n = LONG_HOLD;
            else if (calm)
                n = 0;
            else
                n = $urandom_range(0, 5);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    // Compare every accepted result, field by field, with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending.size() == 0) begin
                $error("unexpected result %0d/%0d overflow %0b",
                       o_sum_numerator, o_sum_denominator, o_overflow);
                fails++;
            end else begin
                head = pending.pop_front();
                if (o_sum_numerator !== head.num) begin
                    $error("sum_numerator: expected %0d, got %0d", head.num, o_sum_numerator);
                    fails++;
                end
                if (o_sum_denominator !== head.den) begin
                    $error("sum_denominator: expected %0d, got %0d",
                           head.den, o_sum_denominator);
                    fails++;
                end
                if (o_overflow !== head.ovf) begin
                    $error("overflow: expected %0b, got %0b", head.ovf, o_overflow);
                    fails++;
                end
            end
        end
    end

    // Watchdog: drop the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else if (quiet == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int i, j;
        clear_sum();

        // plain sums; the model works these out
        add_case("1/2+1/3", 0, 0, 0, 0, 0);
        add_case("-200/7+13/9-1/3", 0, 0, 0, 0, 0);
        add_case("5/3-7/2+1/6", 0, 0, 0, 0, 0);
        // results that read straight off the text
        add_case("-1/2", 0, 1, -1, 2, 0);
        add_case("3", 0, 1, 3, 1, 0);             // no slash: whole number
        add_case("1/0", 0, 1, 1, 1, 0);           // zero denominator counts as 1
        add_case("7/", 0, 1, 7, 1, 0);            // slash without digits
        add_case("/3", 0, 1, 0, 1, 0);            // numerator missing
        add_case("1//2", 0, 1, 1, 2, 0);          // second slash dropped
        add_case("--+-1/4", 0, 1, -1, 4, 0);      // last sign wins
        add_case("1 a/2", 0, 1, 1, 2, 0);         // stray characters dropped
        add_case("1/2\377", 0, 1, 1, 2, 0);       // end mark on code 255
        add_case("1/2+", 0, 1, 1, 2, 0);          // end mark on a trailing sign
        add_case("999/1000", 0, 1, 1, 1, 0);      // both operands saturate
        add_case("12/36", 0, 1, 1, 3, 0);
        add_case("0/5", 0, 1, 0, 1, 0);
        add_case("1/2-1/2", 0, 1, 0, 1, 0);       // cancels to zero
        add_case("255/1", 0, 1, 255, 1, 0);
        add_case("", 1, 1, 0, 1, 0);              // empty: end mark on code 0
        add_case("+", 0, 1, 0, 1, 0);             // sign alone
        // reduced denominator beyond 31 bits
        add_case("1/251+1/241+1/239+1/233", 0, 1, 0, 1, 1);
        // accumulator overflow on the sixth term; later terms are skipped
        add_case("1/255+1/254+1/253+1/251+1/249+1/247+1/245", 1, 1, 0, 1, 1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < cases.size(); i++) begin
            expr_q.delete();
            for (j = 0; j < cases[i].text.len(); j++)
                put_char(cases[i].text[j]);
            if (cases[i].nul_end)
                put_char(8'h00);
            calm = (i % 6 == 5);
            run_expr(cases[i].typed, cases[i].want);
        end

        sent_words = 0;
        while (sent_words < RANDOM_WORDS) begin
            build_expr();
            calm = ($urandom_range(0, 3) == 0);
            run_expr(1'b0, head);
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;

        // wait for every owed result, then give stray ones time to show up
        while (pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
